### src/lbgs_pkg.sv
// Package for the life board generation step block.
// Holds shared constants, codes, state encoding and the cell window type.
// No dependencies.
`default_nettype none

package lbgs_pkg;

  // Default board size.
  localparam int MAX_COLS_DEF = 64;
  localparam int MAX_ROWS_DEF = 64;

  // Configuration register port.
  localparam int REG_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd1;
  localparam logic [REG_W-1:0]     REG_RESET = 7'd64;

  // Neighbor counts of the life rule.
  localparam logic [3:0] NB_KEEP  = 4'd2;
  localparam logic [3:0] NB_BIRTH = 4'd3;

  // Operation codes of an input beat. The unused code acts as a read.
  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_STEP  = 2'd1,
    MODE_READ  = 2'd2
  } mode_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR = 3'd0,
    ST_IDLE  = 3'd1,
    ST_LOOK  = 3'd2,
    ST_GEN   = 3'd3,
    ST_ISSUE = 3'd4,
    ST_DONE  = 3'd5
  } state_t;

  // Three vertically stacked cells of one column.
  typedef struct packed {
    logic up;
    logic cur;
    logic dn;
  } win_t;

endpackage

`default_nettype wire

### src/lbgs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lbgs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### src/lbgs_cell.sv
// One column cell: holds a three-row window of its column and applies the life rule.
// Depends on lbgs_pkg.
`default_nettype none

module lbgs_cell (
  input  wire logic          clk,
  input  wire logic          win_clr,
  input  wire logic          win_shift,
  input  wire logic          dn_in,
  input  wire logic          col_en,
  input  lbgs_pkg::win_t     left_win,
  input  lbgs_pkg::win_t     right_win,
  output lbgs_pkg::win_t     win_out,
  output logic               new_bit
);

  lbgs_pkg::win_t win_r;
  logic [3:0]     cnt;

  // The window moves down the board one row per shift.
  always_ff @(posedge clk) begin
    if (win_clr) begin
      win_r <= '0;
    end else if (win_shift) begin
      win_r.up  <= win_r.cur;
      win_r.cur <= win_r.dn;
      win_r.dn  <= dn_in;
    end
  end

  // Columns out of use look dead to their neighbors.
  assign win_out = col_en ? win_r : '0;

  // Count the eight neighbors and apply the rule; unused columns keep their bit.
  always_comb begin
    cnt = 4'(left_win.up) + 4'(left_win.cur) + 4'(left_win.dn)
        + 4'(win_r.up) + 4'(win_r.dn)
        + 4'(right_win.up) + 4'(right_win.cur) + 4'(right_win.dn);
    if (col_en) begin
      new_bit = (cnt == lbgs_pkg::NB_BIRTH) || ((cnt == lbgs_pkg::NB_KEEP) && win_r.cur);
    end else begin
      new_bit = win_r.cur;
    end
  end

endmodule

`default_nettype wire

### src/lbgs_chain.sv
// Row of column cells: one new board row per cycle while win_shift is high.
// Depends on lbgs_pkg and lbgs_cell.
`default_nettype none

module lbgs_chain #(
  parameter int MAX_COLS = lbgs_pkg::MAX_COLS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           win_clr,
  input  wire logic                           win_shift,
  input  wire logic [MAX_COLS-1:0]            dn_row,
  input  wire logic [$clog2(MAX_COLS+1)-1:0]  eff_cols,
  output logic      [MAX_COLS-1:0]            new_row
);

  localparam int CE_W = $clog2(MAX_COLS + 1);

  lbgs_pkg::win_t wins [MAX_COLS];

  // Each cell sees its neighbors' windows; beyond the board edges all is dead.
  for (genvar c = 0; c < MAX_COLS; c++) begin : g_cell
    lbgs_pkg::win_t left_w;
    lbgs_pkg::win_t right_w;

    if (c == 0) begin : g_left_edge
      assign left_w = '0;
    end else begin : g_left
      assign left_w = wins[c-1];
    end

    if (c == MAX_COLS - 1) begin : g_right_edge
      assign right_w = '0;
    end else begin : g_right
      assign right_w = wins[c+1];
    end

    lbgs_cell u_cell (
      .clk       (clk),
      .win_clr   (win_clr),
      .win_shift (win_shift),
      .dn_in     (dn_row[c]),
      .col_en    (CE_W'(c) < eff_cols),
      .left_win  (left_w),
      .right_win (right_w),
      .win_out   (wins[c]),
      .new_bit   (new_row[c])
    );
  end

endmodule

`default_nettype wire

### src/life_board_generation_step.sv
// Life board: a bounded bit board of live cells with write, advance and read beats.
// Input channel in_*: in_mode selects write cell, advance one generation or read
// cell (the unused code reads); in_col and in_row address a cell and in_cell_value
// is the state written. Output channel out_*: one beat per input beat carrying
// out_cell_alive, the addressed cell's state after the operation (0 off the board).
// Config channel cfg_*: cfg_index 0 sets the column count, 1 the row count in use;
// cfg_ready is always high.
// A write or read reads the addressed row, settles its result in ST_LOOK and loads
// it into the output register from ST_DONE. An advance sweeps the board one row per
// cycle with a three-row window in a row of column cells, reading one row and writing
// one row of the board RAM per cycle, then reads the addressed cell like a read.
// A new input beat is taken once the previous beat's result has moved into the output
// register, also while it still waits there, not while the previous beat is in work.
// Reset: a clearing pass writes every RAM row dead with in_ready low; configuration
// beats are taken during it. Registers reset to 64.
// If the receiver stalls, at most one further result is held and input stops.
// Depends on lbgs_pkg, lbgs_ram, lbgs_chain and lbgs_cell.
`default_nettype none

module life_board_generation_step #(
  parameter int MAX_COLS = lbgs_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = lbgs_pkg::MAX_ROWS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [1:0]                     in_mode,
  input  wire logic [5:0]                     in_col,
  input  wire logic [5:0]                     in_row,
  input  wire logic                           in_cell_value,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_cell_alive,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [lbgs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lbgs_pkg::REG_W-1:0]     cfg_data
);

  localparam int AW           = $clog2(MAX_ROWS);
  localparam int CW           = $clog2(MAX_COLS);
  localparam int CE_W         = $clog2(MAX_COLS + 1);
  localparam int ROWS_EFF_MAX = (MAX_ROWS < 127) ? MAX_ROWS : 127;
  localparam int RE_W         = $clog2(ROWS_EFF_MAX + 1);
  localparam int STEP_W       = $clog2(ROWS_EFF_MAX + 3);

  lbgs_pkg::state_t state_r, state_nxt;

  logic [lbgs_pkg::REG_W-1:0] cols_r, rows_r;
  logic [CE_W-1:0]            eff_cols;
  logic [RE_W-1:0]            eff_rows;

  logic [STEP_W-1:0] t_r, t_nxt;
  logic [STEP_W-1:0] t_m3;
  logic [STEP_W-1:0] t_last;
  logic [AW-1:0]     clr_addr_r, clr_addr_nxt;
  logic              rd_ok_r, rd_ok_nxt;

  logic [1:0]        mode_r;
  logic [5:0]        col_r, row_r;
  logic              val_r;
  logic              res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_cell_r;
  logic              out_load;
  logic              in_fire;

  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [MAX_COLS-1:0] wdata, rdata, dn_row, new_row, bit_mask;
  logic              win_clr, win_shift;
  logic              phys_ok, in_use, cur_bit;

  // Register values out of range act as the nearest legal count.
  always_comb begin
    if (cols_r == '0) begin
      eff_cols = CE_W'(1);
    end else if (32'(cols_r) > 32'(MAX_COLS)) begin
      eff_cols = CE_W'(MAX_COLS);
    end else begin
      eff_cols = CE_W'(cols_r);
    end
    if (rows_r == '0) begin
      eff_rows = RE_W'(1);
    end else if (32'(rows_r) > 32'(MAX_ROWS)) begin
      eff_rows = RE_W'(MAX_ROWS);
    end else begin
      eff_rows = RE_W'(rows_r);
    end
  end

  // Configuration beats.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= lbgs_pkg::REG_RESET;
      rows_r <= lbgs_pkg::REG_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == lbgs_pkg::REG_COLS) begin
        cols_r <= cfg_data;
      end else if (cfg_index == lbgs_pkg::REG_ROWS) begin
        rows_r <= cfg_data;
      end
    end
  end

  // Addressed cell checks for the latched beat.
  assign phys_ok  = (32'(row_r) < 32'(MAX_ROWS)) && (32'(col_r) < 32'(MAX_COLS));
  assign in_use   = (32'(row_r) < 32'(eff_rows)) && (32'(col_r) < 32'(eff_cols));
  assign cur_bit  = rdata[CW'(col_r)];
  assign bit_mask = {{(MAX_COLS-1){1'b0}}, 1'b1} << CW'(col_r);

  // Sweep step arithmetic.
  assign t_m3   = t_r - STEP_W'(3);
  assign t_last = STEP_W'(eff_rows) + STEP_W'(2);
  assign dn_row = rd_ok_r ? rdata : '0;

  assign in_fire = in_valid && in_ready;

  // Next state and datapath control.
  always_comb begin
    state_nxt     = state_r;
    t_nxt         = t_r;
    clr_addr_nxt  = clr_addr_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_load      = 1'b0;
    in_ready      = 1'b0;
    we            = 1'b0;
    waddr         = '0;
    wdata         = '0;
    raddr         = AW'(in_row);
    win_clr       = 1'b0;
    win_shift     = 1'b0;
    rd_ok_nxt     = 1'b0;
    case (state_r)
      lbgs_pkg::ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr_r;
        if (clr_addr_r == AW'(MAX_ROWS - 1)) begin
          state_nxt = lbgs_pkg::ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + AW'(1);
        end
      end
      lbgs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        raddr    = AW'(in_row);
        if (in_valid) begin
          if (in_mode == lbgs_pkg::MODE_STEP) begin
            state_nxt = lbgs_pkg::ST_GEN;
            t_nxt     = '0;
            win_clr   = 1'b1;
          end else begin
            state_nxt = lbgs_pkg::ST_LOOK;
          end
        end
      end
      lbgs_pkg::ST_GEN: begin
        // Read row t, shift in row t-1, write the new row t-3.
        raddr     = AW'(t_r);
        rd_ok_nxt = STEP_W'(eff_rows) > t_r;
        win_shift = t_r != '0;
        if (t_r >= STEP_W'(3)) begin
          we    = 1'b1;
          waddr = AW'(t_m3);
          wdata = new_row;
        end
        if (t_r == t_last) begin
          state_nxt = lbgs_pkg::ST_ISSUE;
        end else begin
          t_nxt = t_r + STEP_W'(1);
        end
      end
      lbgs_pkg::ST_ISSUE: begin
        raddr     = AW'(row_r);
        state_nxt = lbgs_pkg::ST_LOOK;
      end
      lbgs_pkg::ST_LOOK: begin
        if ((mode_r == lbgs_pkg::MODE_WRITE) && in_use) begin
          we      = 1'b1;
          waddr   = AW'(row_r);
          wdata   = val_r ? (rdata | bit_mask) : (rdata & ~bit_mask);
          res_nxt = val_r;
        end else begin
          res_nxt = phys_ok && cur_bit;
        end
        state_nxt = lbgs_pkg::ST_DONE;
      end
      lbgs_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = lbgs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lbgs_pkg::ST_IDLE;
      end
    endcase
  end

  // State register and control counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lbgs_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      t_r         <= '0;
      rd_ok_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      t_r         <= t_nxt;
      rd_ok_r     <= rd_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers of the current beat and the result.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r <= in_mode;
      col_r  <= in_col;
      row_r  <= in_row;
      val_r  <= in_cell_value;
    end
    res_r <= res_nxt;
    if (out_load) begin
      out_cell_r <= res_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_alive = out_cell_r;

  // Board storage.
  lbgs_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS)
  ) u_board (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Row of column cells.
  lbgs_chain #(
    .MAX_COLS (MAX_COLS)
  ) u_chain (
    .clk       (clk),
    .win_clr   (win_clr),
    .win_shift (win_shift),
    .dn_row    (dn_row),
    .eff_cols  (eff_cols),
    .new_row   (new_row)
  );

`ifndef NO_ASSERTIONS
  // An accepted beat starts either a lookup or a sweep.
  a_fire_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == lbgs_pkg::ST_LOOK || state_r == lbgs_pkg::ST_GEN))
    else $error("accepted beat did not start work");

  // A result appears only from the completion state.
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == lbgs_pkg::ST_DONE)
    else $error("result loaded outside completion state");

  // The sweep never writes a row beyond the rows in use.
  a_gen_rows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lbgs_pkg::ST_GEN && we) |-> (32'(waddr) < 32'(eff_rows)))
    else $error("sweep wrote outside the rows in use");
`endif

endmodule

`default_nettype wire

### dv/testbench.sv
// Testbench for life_board_generation_step: random and directed write, advance and read beats.
// Every result is checked against a board predictor kept in this file, with idling and stalls.
// Depends on lbgs_pkg and the life_board_generation_step RTL.

module testbench;
  import lbgs_pkg::*;

  localparam int BOARD_COLS    = MAX_COLS_DEF;
  localparam int BOARD_ROWS    = MAX_ROWS_DEF;
  localparam int REPORT_LIMIT  = 10;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 80;
  localparam int LONG_HOLD     = 400;
  localparam int TIMEOUT_UNITS = 5_000_000;

  // The fourth mode code is unused and behaves as a read.
  localparam logic [1:0]           MODE_SPARE = 2'd3;
  // Register index with no register behind it.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           in_mode;
  logic [5:0]           in_col;
  logic [5:0]           in_row;
  logic                 in_cell_value;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_cell_alive;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_data;

  // One pending result, with the beat that caused it for reporting.
  typedef struct {
    logic        alive;
    logic [1:0]  mode;
    logic [5:0]  col;
    logic [5:0]  row;
    int unsigned beat_no;
  } cell_expect_t;

  // Predicted board and register contents.
  logic [BOARD_COLS-1:0] life_board [BOARD_ROWS];
  logic [REG_W-1:0]      cols_reg;
  logic [REG_W-1:0]      rows_reg;

  cell_expect_t alive_expected_q[$];
  bit           idling_on;
  int unsigned  stall_request;
  int unsigned  fault_count;
  int unsigned  beats_sent;

  life_board_generation_step u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_col         (in_col),
    .in_row         (in_row),
    .in_cell_value  (in_cell_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cell_alive (out_cell_alive),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // A count of zero acts as one; a count past the board acts as the board size.
  function automatic int span_of(input logic [REG_W-1:0] reg_val, input int limit);
    if (reg_val == '0) return 1;
    if (int'(reg_val) > limit) return limit;
    return int'(reg_val);
  endfunction

  // One generation over the region in use; all counts come from the old board and
  // cells outside the region neither count nor change.
  function automatic void board_advance();
    logic [BOARD_COLS-1:0] next_gen [BOARD_ROWS];
    int nrows;
    int ncols;
    int alive_nb;
    int rr;
    int cc;
    nrows = span_of(rows_reg, BOARD_ROWS);
    ncols = span_of(cols_reg, BOARD_COLS);
    foreach (life_board[i]) next_gen[i] = life_board[i];
    for (int r = 0; r < nrows; r++) begin
      for (int c = 0; c < ncols; c++) begin
        alive_nb = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            rr = r + dr;
            cc = c + dc;
            if ((dr != 0 || dc != 0) && rr >= 0 && cc >= 0 && rr < nrows && cc < ncols)
              alive_nb += life_board[rr][cc];
          end
        end
        if (alive_nb < int'(NB_KEEP) || alive_nb > int'(NB_BIRTH)) next_gen[r][c] = 1'b0;
        else if (alive_nb == int'(NB_BIRTH)) next_gen[r][c] = 1'b1;
      end
    end
    foreach (life_board[i]) life_board[i] = next_gen[i];
  endfunction

  // Applies one input beat to the predicted board and returns the addressed cell.
  function automatic logic life_predict(input logic [1:0] mode, input logic [5:0] col,
                                        input logic [5:0] row, input logic value);
    case (mode)
      MODE_WRITE: begin
        if (col < span_of(cols_reg, BOARD_COLS) && row < span_of(rows_reg, BOARD_ROWS))
          life_board[row][col] = value;
      end
      MODE_STEP: board_advance();
      default: ;
    endcase
    return life_board[row][col];
  endfunction

  function automatic void log_fault(input string text);
    fault_count++;
    if (fault_count <= REPORT_LIMIT) $display("ERROR: %s", text);
  endfunction

  function automatic logic [REG_W-1:0] pick_span();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    case (pick)
      0: return '0;
      1: return 7'd1;
      2: return 7'd64;
      3: return 7'd127;
      4: return 7'($urandom_range(65, 126));
      5, 6: return 7'($urandom_range(13, 63));
      default: return 7'($urandom_range(2, 12));
    endcase
  endfunction

  // Offers one input beat, holds it until accepted, then records its prediction.
  task automatic send_beat(input logic [1:0] mode, input logic [5:0] col,
                           input logic [5:0] row, input logic value);
    cell_expect_t want;
    int unsigned  gap;
    @(negedge clk);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= mode;
    in_col        <= col;
    in_row        <= row;
    in_cell_value <= value;
    do @(posedge clk); while (!in_ready);
    want.alive   = life_predict(mode, col, row, value);
    want.mode    = mode;
    want.col     = col;
    want.row     = row;
    want.beat_no = beats_sent;
    alive_expected_q.push_back(want);
    beats_sent++;
  endtask

  task automatic send_noise();
    send_beat(2'($urandom_range(0, 3)), 6'($urandom), 6'($urandom), 1'($urandom));
  endtask

  // Stops offering beats and waits until every result is back and the block is idle.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (alive_expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_COLS) cols_reg = value;
    else if (idx == REG_ROWS) rows_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_and_corners();
    // The cleared board reads dead, then corner cells are written, the origin both ways.
    send_beat(MODE_READ, 6'd0, 6'd0, 1'b1);
    send_beat(MODE_WRITE, 6'd63, 6'd63, 1'b1);
    send_beat(MODE_WRITE, 6'd0, 6'd0, 1'b1);
    send_beat(MODE_WRITE, 6'd0, 6'd0, 1'b0);
    // A horizontal blinker; the spare mode code only reads.
    send_beat(MODE_WRITE, 6'd10, 6'd10, 1'b1);
    send_beat(MODE_WRITE, 6'd11, 6'd10, 1'b1);
    send_beat(MODE_WRITE, 6'd12, 6'd10, 1'b1);
    send_beat(MODE_SPARE, 6'd11, 6'd10, 1'b0);
    send_beat(MODE_STEP, 6'd11, 6'd9, 1'b0);
    send_beat(MODE_STEP, 6'd12, 6'd10, 1'b1);
  endtask

  task automatic test_region_limits();
    // Live cells just past the edges of the region set below.
    send_beat(MODE_WRITE, 6'd5, 6'd2, 1'b1);
    send_beat(MODE_WRITE, 6'd2, 6'd4, 1'b1);
    wait_drained();
    write_reg(REG_COLS, 7'd5);
    write_reg(REG_ROWS, 7'd4);
    // Writes past the last column are dropped and return the stored bit.
    send_beat(MODE_WRITE, 6'd5, 6'd1, 1'b1);
    send_beat(MODE_WRITE, 6'd5, 6'd2, 1'b0);
    // Edge cells whose outside neighbors must not be counted.
    send_beat(MODE_WRITE, 6'd4, 6'd1, 1'b1);
    send_beat(MODE_WRITE, 6'd4, 6'd2, 1'b1);
    send_beat(MODE_WRITE, 6'd2, 6'd3, 1'b1);
    send_beat(MODE_WRITE, 6'd1, 6'd3, 1'b1);
    send_beat(MODE_STEP, 6'd4, 6'd2, 1'b0);
    send_beat(MODE_READ, 6'd5, 6'd2, 1'b0);
    send_beat(MODE_READ, 6'd2, 6'd4, 1'b0);
  endtask

  task automatic test_register_extremes();
    // Zero counts act as a single cell; an unused index changes nothing.
    wait_drained();
    write_reg(REG_COLS, '0);
    write_reg(REG_ROWS, '0);
    write_reg(REG_SPARE, 7'h55);
    send_beat(MODE_WRITE, 6'd0, 6'd0, 1'b1);
    send_beat(MODE_WRITE, 6'd1, 6'd0, 1'b1);
    send_beat(MODE_STEP, 6'd0, 6'd0, 1'b0);
    // Counts beyond the board clamp to the full board.
    wait_drained();
    write_reg(REG_COLS, 7'd127);
    write_reg(REG_ROWS, 7'd100);
    send_beat(MODE_WRITE, 6'd63, 6'd63, 1'b0);
    send_beat(MODE_STEP, 6'd63, 6'd62, 1'b0);
  endtask

  task automatic test_output_backpressure();
    // The receiver holds off for a long time while beats keep coming.
    wait_drained();
    idling_on = 1'b1;
    @(posedge clk);
    stall_request = LONG_HOLD;
    repeat (40) send_noise();
  endtask

  // Seeds a small window of the region with a random pattern, then advances it
  // several generations and reads cells of the window in between.
  task automatic run_generation_phase(input bit with_idling);
    int ncols;
    int nrows;
    int w;
    int h;
    int x0;
    int y0;
    int density;
    wait_drained();
    write_reg(REG_COLS, pick_span());
    write_reg(REG_ROWS, pick_span());
    idling_on = with_idling && ($urandom_range(0, 3) != 0);
    ncols = span_of(cols_reg, BOARD_COLS);
    nrows = span_of(rows_reg, BOARD_ROWS);
    w = $urandom_range(3, 7);
    h = $urandom_range(3, 7);
    if (w > ncols) w = ncols;
    if (h > nrows) h = nrows;
    x0 = $urandom_range(0, ncols - w);
    y0 = $urandom_range(0, nrows - h);
    density = $urandom_range(25, 60);
    for (int y = 0; y < h; y++) begin
      for (int x = 0; x < w; x++) begin
        if ($urandom_range(0, 7) == 0) send_noise();
        send_beat(MODE_WRITE, 6'(x0 + x), 6'(y0 + y), $urandom_range(0, 99) < density);
      end
    end
    repeat ($urandom_range(2, 6)) begin
      send_beat(MODE_STEP, 6'(x0 + $urandom_range(0, w - 1)),
                6'(y0 + $urandom_range(0, h - 1)), 1'($urandom));
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 7) == 0) send_noise();
        send_beat(MODE_READ, 6'(x0 + $urandom_range(0, w - 1)),
                  6'(y0 + $urandom_range(0, h - 1)), 1'($urandom));
      end
    end
  endtask

  task automatic test_random_generations();
    while (beats_sent < 640) run_generation_phase(1'b1);
  endtask

  task automatic test_steady_stream();
    while (beats_sent < 720) run_generation_phase(1'b0);
  endtask

  // Result receiver: long holds on request, otherwise random stall bursts.
  initial begin : result_sink
    int unsigned hold_left;
    int unsigned burst_left;
    out_ready  = 1'b0;
    hold_left  = 0;
    burst_left = 0;
    forever begin
      @(negedge clk);
      if (stall_request != 0) begin
        hold_left     = stall_request;
        stall_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (burst_left != 0) begin
        burst_left--;
        out_ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        burst_left = $urandom_range(1, 16) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Each result beat is matched with the oldest pending prediction.
  always @(posedge clk) begin
    cell_expect_t want;
    if (rst_n && out_valid && out_ready) begin
      if (alive_expected_q.size() == 0) begin
        log_fault($sformatf("result beat with none pending, cell_alive %0b", out_cell_alive));
      end else begin
        want = alive_expected_q.pop_front();
        if (out_cell_alive !== want.alive)
          log_fault($sformatf("beat %0d mode %0d col %0d row %0d: cell_alive exp %0b got %0b",
                              want.beat_no, want.mode, want.col, want.row, want.alive,
                              out_cell_alive));
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_UNITS);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : main_seq
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_mode       = MODE_READ;
    in_col        = '0;
    in_row        = '0;
    in_cell_value = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_COLS;
    cfg_data      = '0;
    idling_on     = 1'b1;
    stall_request = 0;
    fault_count   = 0;
    beats_sent    = 0;
    cols_reg      = REG_RESET;
    rows_reg      = REG_RESET;
    foreach (life_board[i]) life_board[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_and_corners();
    test_region_limits();
    test_register_extremes();
    test_output_backpressure();
    test_random_generations();
    test_steady_stream();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0 && alive_expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
src/lbgs_pkg.sv
src/lbgs_ram.sv
src/lbgs_cell.sv
src/lbgs_chain.sv
src/life_board_generation_step.sv
dv/testbench.sv
